FILE: hdl/ucdw_pkg.sv
// Package for the configuration descriptor walker.
// Holds the window size, derived widths, descriptor codes and the transaction types.
// No dependencies.
package ucdw_pkg;

    // bytes looked at per buffer, 8 to 256
    localparam int WINDOW = 64;

    // byte position saturates at WINDOW, so it must hold WINDOW itself
    localparam int POS_W = $clog2(WINDOW + 1);
    // a descriptor end is a position plus a length byte
    localparam int NDS_W = ((POS_W > 8) ? POS_W : 8) + 1;

    // offsets inside a descriptor
    localparam logic [NDS_W-1:0] OFS_KIND     = NDS_W'(1);
    localparam logic [NDS_W-1:0] OFS_ADDR     = NDS_W'(2);
    localparam logic [NDS_W-1:0] OFS_ATTR     = NDS_W'(3);
    localparam logic [NDS_W-1:0] OFS_SIZE_LO  = NDS_W'(4);
    localparam logic [NDS_W-1:0] OFS_SIZE_HI  = NDS_W'(5);
    localparam logic [NDS_W-1:0] OFS_INTERVAL = NDS_W'(6);

    // fixed buffer positions of the header fields
    localparam logic [POS_W-1:0] POS_TOTAL_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TOTAL_HI = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CONFIG   = POS_W'(5);

    localparam logic [7:0] KIND_ENDPOINT    = 8'd5;
    localparam logic [7:0] ENDPOINT_MIN_LEN = 8'd7;
    localparam logic [7:0] MIN_DESC_LEN     = 8'd2;
    localparam logic [7:0] DIR_IN_BIT       = 8'h80;
    localparam logic [1:0] XFER_INTERRUPT   = 2'h3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  endpoint_address;
        logic [15:0] max_packet_size;
        logic [7:0]  poll_interval;
        logic [7:0]  cfg_value;
        logic [15:0] total_length;
    } result_t;

endpackage

FILE: hdl/usb_config_descriptor_walker_core.sv
// Top level of the configuration descriptor walker: input staging register,
// walker instance and result register. Depends on ucdw_pkg and ucdw_walker.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  ucdw_pkg::item_t   (one descriptor byte)
//  m_       out  m_valid / m_ready  ucdw_pkg::result_t (one per buffer)
//
// One byte per cycle while nothing stalls: each byte is held in the staging register, where the
// walker state update runs, and a buffer's result is registered from its staged last byte.
// Synchronous active-low reset clears both stages and the walker state.
// A held result stalls only a staged last byte; other bytes keep flowing.
module usb_config_descriptor_walker_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ucdw_pkg::item_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ucdw_pkg::result_t m_data
);

    logic              in_valid_reg;
    ucdw_pkg::item_t   in_data_reg;
    logic              out_valid_reg;
    ucdw_pkg::result_t out_data_reg;
    ucdw_pkg::result_t walk_result;
    logic              advance;

    // a staged last byte needs room in the result register
    assign advance = in_valid_reg &&
                     (!in_data_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    ucdw_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .result  (walk_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_data_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_data_reg.last_byte) begin
            out_data_reg <= walk_result;
        end
    end

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_data_reg.last_byte))
        else $error("result appeared without a staged last byte");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_data_reg.last_byte && out_valid_reg && !m_ready)
        |=> (in_valid_reg && in_data_reg.last_byte && $stable(out_data_reg)))
        else $error("staged last byte overwrote a held result");

    a_found_is_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.found) |-> out_data_reg.endpoint_address[7])
        else $error("found endpoint is not an IN endpoint");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg.found) |->
        (out_data_reg.endpoint_address == 8'd0 && out_data_reg.max_packet_size == 16'd0 &&
         out_data_reg.poll_interval == 8'd0))
        else $error("endpoint fields nonzero without a found endpoint");

endmodule

FILE: hdl/ucdw_walker.sv
// Walker state and per-byte update logic for the configuration descriptor walker.
// Depends on ucdw_pkg; driven by the staging and output registers in the top level.
module ucdw_walker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ucdw_pkg::item_t   item,
    output ucdw_pkg::result_t result
);

    localparam int POS_W = ucdw_pkg::POS_W;
    localparam int NDS_W = ucdw_pkg::NDS_W;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [NDS_W-1:0] nds_reg, nds_next;
    logic [7:0]       dlen_reg, dlen_next;
    logic [7:0]       kind_reg, kind_next;
    logic             stopped_reg, stopped_next;
    logic             found_reg;
    logic [7:0]       paddr_reg, paddr_next;
    logic [7:0]       pattr_reg, pattr_next;
    logic [15:0]      psize_reg, psize_next;
    logic [7:0]       caddr_reg;
    logic [15:0]      csize_reg;
    logic [7:0]       cint_reg;
    logic [7:0]       config_reg, config_next;
    logic [15:0]      total_reg, total_next;

    logic [NDS_W-1:0] p_ext, b_ext, start_w, offset, q, fin_start;
    logic             walk_judge, fin_go, judge;
    logic [7:0]       interval;

    always_comb begin
        pos_next     = pos_reg;
        nds_next     = nds_reg;
        dlen_next    = dlen_reg;
        kind_next    = kind_reg;
        stopped_next = stopped_reg;
        paddr_next   = paddr_reg;
        pattr_next   = pattr_reg;
        psize_next   = psize_reg;
        config_next  = config_reg;
        total_next   = total_reg;
        walk_judge   = 1'b0;
        p_ext        = NDS_W'(pos_reg);
        b_ext        = NDS_W'(item.data_byte);
        start_w      = nds_reg - NDS_W'(dlen_reg);
        offset       = p_ext - start_w;

        if (pos_reg < POS_W'(ucdw_pkg::WINDOW)) begin
            if (pos_reg == ucdw_pkg::POS_TOTAL_LO) begin
                total_next[7:0] = item.data_byte;
            end else if (pos_reg == ucdw_pkg::POS_TOTAL_HI) begin
                total_next[15:8] = item.data_byte;
            end else if (pos_reg == ucdw_pkg::POS_CONFIG) begin
                config_next = item.data_byte;
            end
            pos_next = pos_reg + POS_W'(1);

            if (!stopped_reg) begin
                if (p_ext == nds_reg) begin
                    // a new descriptor header, or the end of the walk
                    if ((p_ext + NDS_W'(1)) >= NDS_W'(ucdw_pkg::WINDOW) ||
                        item.data_byte < ucdw_pkg::MIN_DESC_LEN) begin
                        stopped_next = 1'b1;
                    end else begin
                        dlen_next  = item.data_byte;
                        kind_next  = 8'd0;
                        paddr_next = 8'd0;
                        pattr_next = 8'd0;
                        psize_next = 16'd0;
                        nds_next   = p_ext + b_ext;
                    end
                end else if (p_ext >= start_w && p_ext < nds_reg) begin
                    unique case (offset)
                        ucdw_pkg::OFS_KIND:     kind_next = item.data_byte;
                        ucdw_pkg::OFS_ADDR:     paddr_next = item.data_byte;
                        ucdw_pkg::OFS_ATTR:     pattr_next = item.data_byte;
                        ucdw_pkg::OFS_SIZE_LO:  psize_next = {8'd0, item.data_byte};
                        ucdw_pkg::OFS_SIZE_HI:  psize_next[15:8] = item.data_byte;
                        ucdw_pkg::OFS_INTERVAL: walk_judge = 1'b1;
                        default: ;
                    endcase
                end
            end
        end

        // last byte inside an unfinished endpoint: missing bytes read as zero
        q         = NDS_W'(pos_next) - NDS_W'(1);
        fin_start = nds_next - NDS_W'(dlen_next);
        fin_go    = item.last_byte && !stopped_next &&
                    dlen_next >= ucdw_pkg::MIN_DESC_LEN && nds_next > q &&
                    fin_start <= q && (q - fin_start) < ucdw_pkg::OFS_INTERVAL;

        judge = (walk_judge || fin_go) && !found_reg &&
                kind_next == ucdw_pkg::KIND_ENDPOINT &&
                dlen_next >= ucdw_pkg::ENDPOINT_MIN_LEN &&
                (paddr_next & ucdw_pkg::DIR_IN_BIT) != 8'd0 &&
                pattr_next[1:0] == ucdw_pkg::XFER_INTERRUPT;
        interval = walk_judge ? item.data_byte : 8'd0;

        result.found            = found_reg || judge;
        result.endpoint_address = judge ? paddr_next : caddr_reg;
        result.max_packet_size  = judge ? psize_next : csize_reg;
        result.poll_interval    = judge ? interval : cint_reg;
        result.cfg_value        = config_next;
        result.total_length     = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && item.last_byte)) begin
            // every buffer starts from the reset state
            pos_reg     <= '0;
            nds_reg     <= '0;
            dlen_reg    <= '0;
            kind_reg    <= '0;
            stopped_reg <= 1'b0;
            found_reg   <= 1'b0;
            paddr_reg   <= '0;
            pattr_reg   <= '0;
            psize_reg   <= '0;
            caddr_reg   <= '0;
            csize_reg   <= '0;
            cint_reg    <= '0;
            config_reg  <= '0;
            total_reg   <= '0;
        end else if (step_en) begin
            pos_reg     <= pos_next;
            nds_reg     <= nds_next;
            dlen_reg    <= dlen_next;
            kind_reg    <= kind_next;
            stopped_reg <= stopped_next;
            found_reg   <= result.found;
            paddr_reg   <= paddr_next;
            pattr_reg   <= pattr_next;
            psize_reg   <= psize_next;
            caddr_reg   <= result.endpoint_address;
            csize_reg   <= result.max_packet_size;
            cint_reg    <= result.poll_interval;
            config_reg  <= config_next;
            total_reg   <= total_next;
        end
    end

endmodule
